// ----- rtl/dq_pkg.sv -----
// shared constants and types for the double-ended queue
// no dependencies

package dq_pkg;

    localparam int DQ_CAPACITY = 16;

    localparam logic signed [31:0] EMPTY_WORD = -32'sd1;

    // request opcodes, codes five to seven act as a query
    localparam logic [2:0] OP_QUERY      = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_PUSH_REAR  = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_POP_REAR   = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_OUT  = 3'b100
    } t_state;

endpackage

// ----- rtl/double_ended_queue_top.sv -----
// bounded double-ended queue of signed 32-bit words in a ring store
// depends on dq_pkg

// The queue holds up to CAPACITY signed 32-bit words in a single ring memory
// with one write port and two registered read ports. Each request pushes at
// the front or rear, pops the front or rear, or only queries; every request
// gives exactly one result with the front and rear words after the request
// (-1 when the queue is empty), the number of stored words, and a status:
// 0 ok, 1 pop or query on an empty queue, 2 push on a full queue (the word
// is dropped). Requests are handled one at a time in steps: the accept cycle
// updates the indices and writes the pushed word, the registered memory read
// then fetches the new front and rear entries, and the result is then held
// until the result side takes it. The input side is ready again in the cycle
// after the result is taken. No clearing pass is needed after reset: only
// occupied entries are ever shown in a result.

module double_ended_queue_top
    import dq_pkg::*;
#(
    parameter int CAPACITY = DQ_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_opcode,
    input  logic signed [31:0] i_value,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_front_value,
    output logic signed [31:0] o_rear_value,
    output logic [4:0]         o_entry_count,
    output logic [1:0]         o_status
);

    // index covers the ring, count must also hold the full value
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    // control state
    t_state        r_state, n_state;
    logic [IW-1:0] r_front, n_front;
    logic [IW-1:0] r_rear,  n_rear;
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    r_status, n_status;

    // ring memory and its registered read data
    logic signed [31:0] r_mem [CAPACITY];
    logic signed [31:0] r_rd_front;
    logic signed [31:0] r_rd_rear;

    // write port, used only in the accept cycle
    logic               wr_en;
    logic [IW-1:0]      wr_addr;

    logic accept;
    logic is_empty;
    logic is_full;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign is_empty   = (r_count == '0);
    assign is_full    = (r_count >= FULL_CNT);

    // ring stepping in both directions, works for any capacity
    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
        ring_next = (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] idx);
        ring_prev = (idx == '0) ? LAST_IDX : idx - 1'b1;
    endfunction

    // index, count and status update for the accepted request
    always_comb begin
        n_front  = r_front;
        n_rear   = r_rear;
        n_count  = r_count;
        n_status = ST_OK;
        wr_en    = 1'b0;
        wr_addr  = r_front;
        case (i_opcode)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
                if (is_full) begin
                    // word is dropped, state unchanged
                    n_status = ST_FULL;
                end else if (is_empty) begin
                    // first word lands at the front slot, both ends point there
                    wr_en   = 1'b1;
                    wr_addr = r_front;
                    n_rear  = r_front;
                    n_count = CW'(1);
                end else if (i_opcode == OP_PUSH_FRONT) begin
                    wr_en   = 1'b1;
                    wr_addr = ring_prev(r_front);
                    n_front = ring_prev(r_front);
                    n_count = r_count + 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = ring_next(r_rear);
                    n_rear  = ring_next(r_rear);
                    n_count = r_count + 1'b1;
                end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else if (r_count == CW'(1)) begin
                    // last word gone, indices stay where they are
                    n_count = '0;
                end else begin
                    if (i_opcode == OP_POP_FRONT) begin
                        n_front = ring_next(r_front);
                    end else begin
                        n_rear = ring_prev(r_rear);
                    end
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                // query and the unused codes
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end
            end
        endcase
    end

    // sequencer: accept and write, read, hand over
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_front  <= '0;
            r_rear   <= '0;
            r_count  <= '0;
            r_status <= ST_OK;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_front  <= n_front;
                r_rear   <= n_rear;
                r_count  <= n_count;
                r_status <= n_status;
            end
        end
    end

    // memory write port, the read in the next cycle already sees the word
    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            r_mem[wr_addr] <= i_value;
        end
    end

    // two read ports on the current ends; stable while the result waits
    always_ff @(posedge i_clk) begin
        r_rd_front <= r_mem[r_front];
        r_rd_rear  <= r_mem[r_rear];
    end

    // result: empty queue shows -1 on both ends
    assign o_out_valid   = (r_state == S_OUT);
    assign o_front_value = is_empty ? EMPTY_WORD : r_rd_front;
    assign o_rear_value  = is_empty ? EMPTY_WORD : r_rd_rear;
    assign o_entry_count = 5'(r_count);
    assign o_status      = r_status;

    // count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above capacity");

    // an accepted request gives its result after the read state
    a_result_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_out_valid)
        else $error("result not presented after request");

    // a dropped push only happens on a full queue and leaves it full
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> (r_count == FULL_CNT))
        else $error("full status with room left");

    // empty status only with an empty queue
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_EMPTY) |-> is_empty)
        else $error("empty status on a non-empty queue");

    // indices and count hold while a result is in flight
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_OUT)
            |=> ($stable(r_front) && $stable(r_rear) && $stable(r_count)))
        else $error("queue state changed during result");

endmodule
